[sv/spi_seq_pkg.sv]
// ----------------------------------------------------------------------------
// SPI NOR command sequencer package
// Payload types, command and item codes, and the sequence table that the
// back end steps through to produce serial items.
// ----------------------------------------------------------------------------
package spi_seq_pkg;

   localparam int ADDR_FIELD_W = 24;
   localparam int QUEUE_DEPTH  = 4;
   localparam int ROM_ENTRIES  = 52;
   localparam int ROM_PTR_W    = 6;

   typedef enum logic [3:0] {
      CMD_PROG_START   = 4'd0,
      CMD_PROG_BYTE    = 4'd1,
      CMD_READ_START   = 4'd2,
      CMD_READ_BYTE    = 4'd3,
      CMD_SINGLE_READ  = 4'd4,
      CMD_SECTOR_ERASE = 4'd5,
      CMD_BULK_ERASE   = 4'd6,
      CMD_READ_STATUS  = 4'd7,
      CMD_READ_ID      = 4'd8
   } cmd_code_type;

   typedef enum logic [1:0] {
      KIND_XFER    = 2'd0,
      KIND_WAIT    = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   localparam logic [7:0] OP_WRSR   = 8'h01;
   localparam logic [7:0] SR_VALUE  = 8'h02;
   localparam logic [7:0] OP_PP     = 8'h02;
   localparam logic [7:0] OP_READ   = 8'h03;
   localparam logic [7:0] OP_RDSR   = 8'h05;
   localparam logic [7:0] OP_WREN   = 8'h06;
   localparam logic [7:0] OP_SE     = 8'h20;
   localparam logic [7:0] OP_BE     = 8'hc7;
   localparam logic [7:0] OP_RDID   = 8'h9f;
   localparam logic [7:0] DUMMY     = 8'h00;

   typedef struct packed {
      logic [3:0]              cmd;
      logic [ADDR_FIELD_W-1:0] addr;
      logic [7:0]              data_byte;
      logic                    data_last;
   } req_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [7:0]              spi_byte;
      logic                    cs_begin;
      logic                    cs_end;
      logic                    capture;
      logic [ADDR_FIELD_W-1:0] next_address;
      logic                    last;
   } rsp_type;

   // One classified command as it travels from the front end to the back end.
   typedef struct packed {
      logic                    rel_first;
      logic                    has_seq;
      logic [ROM_PTR_W-1:0]    start;
      logic [ADDR_FIELD_W-1:0] addr;
      logic [7:0]              data;
      logic                    flag;
      logic [ADDR_FIELD_W-1:0] next_address;
   } seq_desc_type;

   typedef enum logic [2:0] {
      SRC_CONST    = 3'd0,
      SRC_ADDR_HI  = 3'd1,
      SRC_ADDR_MID = 3'd2,
      SRC_ADDR_LO  = 3'd3,
      SRC_DATA     = 3'd4
   } byte_src_type;

   typedef enum logic [1:0] {
      END_NO   = 2'd0,
      END_YES  = 2'd1,
      END_FLAG = 2'd2
   } end_sel_type;

   typedef struct packed {
      logic [1:0]   kind;
      byte_src_type src;
      logic [7:0]   value;
      logic         cs_begin;
      end_sel_type  end_sel;
      logic         capture;
      logic         stop;
   } rom_entry_type;

   localparam logic [ROM_PTR_W-1:0] SEQ_ERASE_OPEN   = 6'd0;
   localparam logic [ROM_PTR_W-1:0] SEQ_PAGE_OPEN    = 6'd9;
   localparam logic [ROM_PTR_W-1:0] SEQ_PAGE_DATA    = 6'd18;
   localparam logic [ROM_PTR_W-1:0] SEQ_SECTOR_ERASE = 6'd19;
   localparam logic [ROM_PTR_W-1:0] SEQ_BULK_ERASE   = 6'd28;
   localparam logic [ROM_PTR_W-1:0] SEQ_READ_START   = 6'd34;
   localparam logic [ROM_PTR_W-1:0] SEQ_SINGLE_READ  = 6'd39;
   localparam logic [ROM_PTR_W-1:0] SEQ_READ_BYTE    = 6'd45;
   localparam logic [ROM_PTR_W-1:0] SEQ_STATUS       = 6'd46;
   localparam logic [ROM_PTR_W-1:0] SEQ_ID           = 6'd48;

   function automatic rom_entry_type rom_wait();
      rom_entry_type e;
      e = '{kind: KIND_WAIT, src: SRC_CONST, value: DUMMY, cs_begin: 1'b0,
            end_sel: END_NO, capture: 1'b0, stop: 1'b0};
      return e;
   endfunction

   function automatic rom_entry_type rom_xfer(input logic [7:0] value, input logic beg,
                                              input end_sel_type sel, input logic cap,
                                              input logic stop);
      rom_entry_type e;
      e = '{kind: KIND_XFER, src: SRC_CONST, value: value, cs_begin: beg,
            end_sel: sel, capture: cap, stop: stop};
      return e;
   endfunction

   function automatic rom_entry_type rom_addr(input byte_src_type src, input end_sel_type sel,
                                              input logic stop);
      rom_entry_type e;
      e = '{kind: KIND_XFER, src: src, value: DUMMY, cs_begin: 1'b0,
            end_sel: sel, capture: 1'b0, stop: stop};
      return e;
   endfunction

   // Sequence table. Each command starts at one of the SEQ_ entries and runs
   // until an entry with the stop bit. Adjacent waits are already merged.
   function automatic rom_entry_type seq_rom(input logic [ROM_PTR_W-1:0] idx);
      rom_entry_type e;
      unique case (idx)
         // Sector erase ahead of a page open, then the page open itself.
         6'd0:  e = rom_wait();
         6'd1:  e = rom_xfer(OP_WRSR, 1'b1, END_NO, 1'b0, 1'b0);
         6'd2:  e = rom_xfer(SR_VALUE, 1'b0, END_YES, 1'b0, 1'b0);
         6'd3:  e = rom_wait();
         6'd4:  e = rom_xfer(OP_WREN, 1'b1, END_YES, 1'b0, 1'b0);
         6'd5:  e = rom_xfer(OP_SE, 1'b1, END_NO, 1'b0, 1'b0);
         6'd6:  e = rom_addr(SRC_ADDR_HI, END_NO, 1'b0);
         6'd7:  e = rom_addr(SRC_ADDR_MID, END_NO, 1'b0);
         6'd8:  e = rom_addr(SRC_ADDR_LO, END_YES, 1'b0);
         6'd9:  e = rom_wait();
         6'd10: e = rom_xfer(OP_WRSR, 1'b1, END_NO, 1'b0, 1'b0);
         6'd11: e = rom_xfer(SR_VALUE, 1'b0, END_YES, 1'b0, 1'b0);
         6'd12: e = rom_wait();
         6'd13: e = rom_xfer(OP_WREN, 1'b1, END_YES, 1'b0, 1'b0);
         6'd14: e = rom_xfer(OP_PP, 1'b1, END_NO, 1'b0, 1'b0);
         6'd15: e = rom_addr(SRC_ADDR_HI, END_NO, 1'b0);
         6'd16: e = rom_addr(SRC_ADDR_MID, END_NO, 1'b0);
         6'd17: e = rom_addr(SRC_ADDR_LO, END_NO, 1'b0);
         6'd18: begin
            e = rom_addr(SRC_DATA, END_FLAG, 1'b1);
         end
         // Standalone sector erase.
         6'd19: e = rom_wait();
         6'd20: e = rom_xfer(OP_WRSR, 1'b1, END_NO, 1'b0, 1'b0);
         6'd21: e = rom_xfer(SR_VALUE, 1'b0, END_YES, 1'b0, 1'b0);
         6'd22: e = rom_wait();
         6'd23: e = rom_xfer(OP_WREN, 1'b1, END_YES, 1'b0, 1'b0);
         6'd24: e = rom_xfer(OP_SE, 1'b1, END_NO, 1'b0, 1'b0);
         6'd25: e = rom_addr(SRC_ADDR_HI, END_NO, 1'b0);
         6'd26: e = rom_addr(SRC_ADDR_MID, END_NO, 1'b0);
         6'd27: e = rom_addr(SRC_ADDR_LO, END_YES, 1'b1);
         // Bulk erase.
         6'd28: e = rom_wait();
         6'd29: e = rom_xfer(OP_WRSR, 1'b1, END_NO, 1'b0, 1'b0);
         6'd30: e = rom_xfer(SR_VALUE, 1'b0, END_YES, 1'b0, 1'b0);
         6'd31: e = rom_wait();
         6'd32: e = rom_xfer(OP_WREN, 1'b1, END_YES, 1'b0, 1'b0);
         6'd33: e = rom_xfer(OP_BE, 1'b1, END_YES, 1'b0, 1'b1);
         // Read stream start; the frame stays open.
         6'd34: e = rom_wait();
         6'd35: e = rom_xfer(OP_READ, 1'b1, END_NO, 1'b0, 1'b0);
         6'd36: e = rom_addr(SRC_ADDR_HI, END_NO, 1'b0);
         6'd37: e = rom_addr(SRC_ADDR_MID, END_NO, 1'b0);
         6'd38: e = rom_addr(SRC_ADDR_LO, END_NO, 1'b1);
         // Single byte read.
         6'd39: e = rom_wait();
         6'd40: e = rom_xfer(OP_READ, 1'b1, END_NO, 1'b0, 1'b0);
         6'd41: e = rom_addr(SRC_ADDR_HI, END_NO, 1'b0);
         6'd42: e = rom_addr(SRC_ADDR_MID, END_NO, 1'b0);
         6'd43: e = rom_addr(SRC_ADDR_LO, END_NO, 1'b0);
         6'd44: e = rom_xfer(DUMMY, 1'b0, END_YES, 1'b1, 1'b1);
         6'd45: e = rom_xfer(DUMMY, 1'b0, END_FLAG, 1'b1, 1'b1);
         6'd46: e = rom_xfer(OP_RDSR, 1'b1, END_NO, 1'b0, 1'b0);
         6'd47: e = rom_xfer(DUMMY, 1'b0, END_YES, 1'b1, 1'b1);
         6'd48: e = rom_xfer(OP_RDID, 1'b1, END_NO, 1'b0, 1'b0);
         6'd49: e = rom_xfer(DUMMY, 1'b0, END_NO, 1'b1, 1'b0);
         6'd50: e = rom_xfer(DUMMY, 1'b0, END_NO, 1'b1, 1'b0);
         6'd51: e = rom_xfer(DUMMY, 1'b0, END_YES, 1'b1, 1'b1);
         default: begin
            e = rom_wait();
            e.stop = 1'b1;
         end
      endcase
      return e;
   endfunction

endpackage

[sv/spi_seq_mod.sv]
// ----------------------------------------------------------------------------
// Constant modulo unit
// Remainder of a 24-bit address by a fixed divisor, using a
// reciprocal multiply, a back multiply and one corrective subtract.
// ----------------------------------------------------------------------------
module spi_seq_mod
   import spi_seq_pkg::*;
#(
   parameter int DIVISOR = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ADDR_FIELD_W-1:0]    x,
   output logic                       done,
   output logic [$clog2(DIVISOR)-1:0] rem
);

   localparam int REM_W   = $clog2(DIVISOR);
   localparam int RECIP_W = ADDR_FIELD_W + 1;
   localparam int PROD_W  = ADDR_FIELD_W + RECIP_W;
   localparam int DIV_W   = $clog2(DIVISOR + 1);
   localparam longint unsigned RECIP_VAL = (longint'(1) << ADDR_FIELD_W) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic [DIV_W-1:0]   DIV   = DIV_W'(DIVISOR);
   localparam logic [ADDR_FIELD_W:0] DIV_EXT = (ADDR_FIELD_W + 1)'(DIVISOR);

   logic                    v1_ff, v2_ff;
   logic [PROD_W-1:0]       prod_in, prod_ff;
   logic [ADDR_FIELD_W-1:0] x1_ff;
   logic [RECIP_W-1:0]      quot;
   logic [RECIP_W+DIV_W-1:0] back_prod;
   logic [ADDR_FIELD_W:0]   r_in, r_ff, r_fix;

   // The quotient estimate is at most one below the true quotient, so the
   // raw remainder is below twice the divisor.
   assign prod_in   = x * RECIP;
   assign quot      = prod_ff[PROD_W-1:ADDR_FIELD_W];
   assign back_prod = quot * DIV;
   assign r_in      = {1'b0, x1_ff} - back_prod[ADDR_FIELD_W:0];
   assign r_fix     = (r_ff >= DIV_EXT) ? (r_ff - DIV_EXT) : r_ff;
   assign rem       = r_fix[REM_W-1:0];
   assign done      = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      x1_ff   <= x;
      r_ff    <= r_in;
   end

endmodule

[sv/spi_seq_front.sv]
// ----------------------------------------------------------------------------
// SPI NOR command sequencer front end
// Accepts host commands, tracks the program address and open frames, and
// classifies each command into a descriptor for the back end.
// ----------------------------------------------------------------------------
module spi_seq_front
   import spi_seq_pkg::*;
#(
   parameter int ADDR_BITS    = 24,
   parameter int PAGE_BYTES   = 256,
   parameter int SECTOR_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_item,
   output logic         push_valid,
   input  logic         push_ready,
   output seq_desc_type push_item
);

   localparam int PAGE_W = $clog2(PAGE_BYTES);
   localparam int SECT_W = $clog2(SECTOR_BYTES);
   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_BYTES - 1);
   localparam logic [SECT_W-1:0] SECT_LAST = SECT_W'(SECTOR_BYTES - 1);

   logic [ADDR_BITS-1:0] prog_addr_ff, prog_addr_in;
   logic [PAGE_W-1:0]    page_off_ff, page_off_inc, page_rem;
   logic [SECT_W-1:0]    sect_off_ff, sect_off_inc, sect_rem;
   logic                 page_open_ff, page_open_in;
   logic                 read_open_ff, read_open_in;
   logic                 busy_ff;
   logic                 accept, push_any, any_open, at_top, endb, mod_start;
   logic                 page_done, sect_done;
   logic [ADDR_BITS-1:0] start_addr, addr_plus;

   assign accept     = req_valid && req_ready;
   assign req_ready  = push_ready && !busy_ff;
   assign push_valid = accept && push_any;
   assign any_open   = page_open_ff || read_open_ff;
   assign start_addr = ADDR_BITS'(req_item.addr);
   assign addr_plus  = prog_addr_ff + ADDR_BITS'(1);
   assign at_top     = (prog_addr_ff == {ADDR_BITS{1'b1}});
   assign mod_start  = accept && (req_item.cmd == CMD_PROG_START);

   // Offsets within the page and sector follow the address; a wrap of the
   // address space restarts both at zero.
   assign page_off_inc = (at_top || page_off_ff == PAGE_LAST) ? '0 : page_off_ff + 1'b1;
   assign sect_off_inc = (at_top || sect_off_ff == SECT_LAST) ? '0 : sect_off_ff + 1'b1;
   assign endb         = req_item.data_last || (page_off_inc == '0);

   spi_seq_mod #(.DIVISOR(PAGE_BYTES)) u_page_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .x     (ADDR_FIELD_W'(start_addr)),
      .done  (page_done),
      .rem   (page_rem)
   );

   spi_seq_mod #(.DIVISOR(SECTOR_BYTES)) u_sect_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .x     (ADDR_FIELD_W'(start_addr)),
      .done  (sect_done),
      .rem   (sect_rem)
   );

   always_comb begin
      push_any               = 1'b0;
      push_item.rel_first    = any_open;
      push_item.has_seq      = 1'b1;
      push_item.start        = SEQ_PAGE_DATA;
      push_item.addr         = req_item.addr;
      push_item.data         = req_item.data_byte;
      push_item.flag         = req_item.data_last;
      push_item.next_address = ADDR_FIELD_W'(prog_addr_ff);
      prog_addr_in           = prog_addr_ff;
      page_open_in           = 1'b0;
      read_open_in           = 1'b0;
      unique case (req_item.cmd)
         CMD_PROG_START: begin
            push_any               = any_open;
            push_item.has_seq      = 1'b0;
            prog_addr_in           = start_addr;
            push_item.next_address = ADDR_FIELD_W'(start_addr);
         end
         CMD_PROG_BYTE: begin
            push_any               = 1'b1;
            push_item.addr         = ADDR_FIELD_W'(prog_addr_ff);
            push_item.flag         = endb;
            push_item.next_address = ADDR_FIELD_W'(addr_plus);
            prog_addr_in           = addr_plus;
            page_open_in           = !endb;
            if (page_open_ff) begin
               push_item.rel_first = 1'b0;
            end else if (sect_off_ff == '0) begin
               push_item.start = SEQ_ERASE_OPEN;
            end else begin
               push_item.start = SEQ_PAGE_OPEN;
            end
         end
         CMD_READ_START: begin
            push_any        = 1'b1;
            push_item.start = SEQ_READ_START;
            read_open_in    = 1'b1;
         end
         CMD_READ_BYTE: begin
            if (read_open_ff) begin
               push_any            = 1'b1;
               push_item.rel_first = 1'b0;
               push_item.start     = SEQ_READ_BYTE;
               read_open_in        = !req_item.data_last;
            end else begin
               push_any          = page_open_ff;
               push_item.has_seq = 1'b0;
            end
         end
         CMD_SINGLE_READ: begin
            push_any        = 1'b1;
            push_item.start = SEQ_SINGLE_READ;
         end
         CMD_SECTOR_ERASE: begin
            push_any        = 1'b1;
            push_item.start = SEQ_SECTOR_ERASE;
         end
         CMD_BULK_ERASE: begin
            push_any        = 1'b1;
            push_item.start = SEQ_BULK_ERASE;
         end
         CMD_READ_STATUS: begin
            push_any        = 1'b1;
            push_item.start = SEQ_STATUS;
         end
         CMD_READ_ID: begin
            push_any        = 1'b1;
            push_item.start = SEQ_ID;
         end
         default: begin
            // Unknown codes leave every frame and the address as they are.
            page_open_in = page_open_ff;
            read_open_in = read_open_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_addr_ff <= '0;
         page_off_ff  <= '0;
         sect_off_ff  <= '0;
         page_open_ff <= 1'b0;
         read_open_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         if (accept) begin
            prog_addr_ff <= prog_addr_in;
            page_open_ff <= page_open_in;
            read_open_ff <= read_open_in;
         end
         if (mod_start) begin
            busy_ff <= 1'b1;
         end else if (page_done) begin
            busy_ff <= 1'b0;
         end
         if (page_done) begin
            page_off_ff <= page_rem;
         end else if (accept && req_item.cmd == CMD_PROG_BYTE) begin
            page_off_ff <= page_off_inc;
         end
         if (sect_done) begin
            sect_off_ff <= sect_rem;
         end else if (accept && req_item.cmd == CMD_PROG_BYTE) begin
            sect_off_ff <= sect_off_inc;
         end
      end
   end

   // A program start holds off the next command until both offsets are loaded.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      mod_start |=> busy_ff)
      else $error("front end not busy after program start");

   a_done_pair: assert property (@(posedge clock) disable iff (reset)
      page_done == sect_done)
      else $error("page and sector remainders out of step");

endmodule

[sv/spi_seq_queue.sv]
// ----------------------------------------------------------------------------
// SPI NOR command sequencer descriptor queue
// Short FIFO that decouples command classification from item generation.
// ----------------------------------------------------------------------------
module spi_seq_queue
   import spi_seq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  seq_desc_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output seq_desc_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   seq_desc_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != DEPTH_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

[sv/spi_seq_back.sv]
// ----------------------------------------------------------------------------
// SPI NOR command sequencer back end
// Walks the sequence table for the queue head descriptor and emits one serial
// item per cycle into the output register while the receiver keeps up.
// ----------------------------------------------------------------------------
module spi_seq_back
   import spi_seq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  seq_desc_type pop_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_item
);

   logic                 rel_done_ff, started_ff, rsp_valid_ff;
   logic [ROM_PTR_W-1:0] ptr_ff, cur_ptr;
   rsp_type              rsp_item_ff, item;
   rom_entry_type        entry;
   logic                 can_emit, emit, rel_phase, item_done;

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign emit      = pop_valid && can_emit;
   assign rel_phase = pop_item.rel_first && !rel_done_ff;
   assign cur_ptr   = started_ff ? ptr_ff : pop_item.start;
   assign entry     = seq_rom(cur_ptr);
   assign item_done = rel_phase ? !pop_item.has_seq : entry.stop;
   assign pop_ready = emit && item_done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      item.next_address = pop_item.next_address;
      item.last         = item_done;
      if (rel_phase) begin
         item.kind     = KIND_RELEASE;
         item.spi_byte = DUMMY;
         item.cs_begin = 1'b0;
         item.cs_end   = 1'b1;
         item.capture  = 1'b0;
      end else begin
         item.kind     = entry.kind;
         item.cs_begin = entry.cs_begin;
         item.capture  = entry.capture;
         unique case (entry.src)
            SRC_ADDR_HI:  item.spi_byte = pop_item.addr[23:16];
            SRC_ADDR_MID: item.spi_byte = pop_item.addr[15:8];
            SRC_ADDR_LO:  item.spi_byte = pop_item.addr[7:0];
            SRC_DATA:     item.spi_byte = pop_item.data;
            default:      item.spi_byte = entry.value;
         endcase
         unique case (entry.end_sel)
            END_YES:  item.cs_end = 1'b1;
            END_FLAG: item.cs_end = pop_item.flag;
            default:  item.cs_end = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_done_ff  <= 1'b0;
         started_ff   <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            if (item_done) begin
               rel_done_ff <= 1'b0;
               started_ff  <= 1'b0;
            end else if (rel_phase) begin
               rel_done_ff <= 1'b1;
            end else begin
               started_ff <= 1'b1;
               ptr_ff     <= cur_ptr + 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_item_ff <= item;
      end
   end

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (ptr_ff < ROM_PTR_W'(ROM_ENTRIES)))
      else $error("sequence pointer ran past the table");

   a_step_on: assert property (@(posedge clock) disable iff (reset)
      (emit && !item_done && !rel_phase) |=> started_ff)
      else $error("sequence did not advance after a middle item");

endmodule

[sv/spi_nor_flash_command_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns host flash commands into byte exchanges, ready waits and chip-select
// releases for a byte-wide SPI engine.
// ----------------------------------------------------------------------------
// The req_ channel takes one host command per transfer; the rsp_ channel
// returns serial items, each a byte exchange, a wait for flash ready or a
// bare chip-select release, with last set on the final item of a command.
// A command that closes nothing and emits nothing produces no item.
// The front end classifies each command in the cycle it is accepted and
// writes a descriptor into a four-entry queue; the back end turns the head
// descriptor into items, one per cycle while the receiver accepts them,
// from a constant sequence table. The back end emits every item of a
// command before it pops the next descriptor; single-item commands such as
// mid-page program bytes sustain one command per cycle while the receiver
// keeps up. A program start holds req_ready low while the page and sector
// offsets of the new address are computed by the modulo units.
// Reset clears the program address, the open-frame flags and the queue.
// When the receiver stalls, the output register holds its item, the queue
// fills, and req_ready falls once the queue is full.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_unit
   import spi_seq_pkg::*;
#(
   parameter int ADDR_BITS    = 24,
   parameter int PAGE_BYTES   = 256,
   parameter int SECTOR_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic         push_valid, push_ready, pop_valid, pop_ready;
   seq_desc_type push_item, pop_item;

   spi_seq_front #(
      .ADDR_BITS    (ADDR_BITS),
      .PAGE_BYTES   (PAGE_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   spi_seq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   spi_seq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
